@@ rtl/swqt_pkg.sv @@
// swqt_pkg: operation and status codes of the semaphore wait queue table
// no dependencies
`default_nettype none

package swqt_pkg;

   // operation codes of a request transaction
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_OUT    = 2'd2,
      OP_HEAD   = 2'd3
   } op_type;

   // status codes of a response transaction
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

endpackage : swqt_pkg

`default_nettype wire

@@ rtl/semaphore_wait_queue_table_unit.sv @@
// semaphore_wait_queue_table_unit: semaphore descriptor table with per-key
// process wait queues, held in synchronous memories; depends on swqt_pkg
//
// usage:
//   request channel (req_valid / req_stall) carries operation, sem_key and
//   proc_id; response channel (rsp_valid / rsp_stall) carries status and
//   result_proc. one response transaction per request transaction.
//   one request is worked on at a time; req_stall is high while busy.
// request processing:
//   insert and remove/peek by key run the key search, which reads one
//   descriptor key per cycle from the key memory and stops at the first
//   match; out by process takes its descriptor from the process entry;
//   rejected insert/out (bad or wrong-state process) skip the table.
// reset: synchronous; clears the descriptor active and process blocked
//   flags, so the table starts empty; memories are not cleared.
// receiver stall: the finished response is held in the output register;
//   a following result waits in its final state, with no table update,
//   until the output register is free.
`default_nettype none

module semaphore_wait_queue_table_unit
   import swqt_pkg::*;
#(
   parameter int MAX_PROCS = 32,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_sem_key,
   input  wire logic [4:0]  req_proc_id,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [4:0]  rsp_result_proc
);

   localparam int IW = $clog2(MAX_PROCS);
   localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_REJ, S_SCAN, S_FIN, S_PDI, S_PDIW, S_HTA, S_HTD, S_NPD
   } state_type;

   // control and registered outputs
   state_type               state_ff;
   op_type                  op_ff;
   logic [KEY_WIDTH-1:0]    key_ff;
   logic [IW-1:0]           p_ff;
   logic [IW-1:0]           d_ff;
   logic [IW-1:0]           h_ff;
   logic [IW-1:0]           t_ff;
   logic [IW-1:0]           px_ff;
   logic [IW-1:0]           cnt_ff;
   logic                    issue_done_ff;
   logic [IW-1:0]           cmp_idx_ff;
   logic                    cmp_vld_ff;
   logic                    free_fnd_ff;
   logic [IW-1:0]           free_idx_ff;
   logic [MAX_PROCS-1:0]    active_ff;
   logic [MAX_PROCS-1:0]    blocked_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [4:0]              rsp_result_proc_ff;

   // memories and their registered read data
   logic [KEY_WIDTH-1:0]    key_mem [MAX_PROCS];
   logic [IW-1:0]           head_mem [MAX_PROCS];
   logic [IW-1:0]           tail_mem [MAX_PROCS];
   logic [IW-1:0]           next_mem [MAX_PROCS];
   logic [IW-1:0]           prev_mem [MAX_PROCS];
   logic [IW-1:0]           pdi_mem [MAX_PROCS];
   logic [KEY_WIDTH-1:0]    key_rd;
   logic [IW-1:0]           head_rd;
   logic [IW-1:0]           tail_rd;
   logic [IW-1:0]           next_rd;
   logic [IW-1:0]           prev_rd;
   logic [IW-1:0]           pdi_rd;

   // memory write ports
   logic                    key_we;
   logic [IW-1:0]           key_wa;
   logic                    head_we;
   logic [IW-1:0]           head_wa;
   logic [IW-1:0]           head_wd;
   logic                    tail_we;
   logic [IW-1:0]           tail_wa;
   logic [IW-1:0]           tail_wd;
   logic                    next_we;
   logic [IW-1:0]           next_wa;
   logic [IW-1:0]           next_wd;
   logic                    prev_we;
   logic [IW-1:0]           prev_wa;
   logic [IW-1:0]           prev_wd;
   logic                    pdi_we;
   logic [IW-1:0]           pdi_wa;
   logic [IW-1:0]           pdi_wd;
   logic [IW-1:0]           np_ra;

   logic                    req_acc;
   logic                    out_free;
   logic                    p_in_range;
   logic [IW-1:0]           p_in;
   logic                    cmp_hit;
   logic                    cmp_last;
   logic [IW-1:0]           px;
   logic                    at_head;
   logic                    at_tail;

   assign req_stall       = (state_ff != S_IDLE);
   assign req_acc         = req_valid && !req_stall;
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_proc = rsp_result_proc_ff;

   assign p_in_range = ({27'd0, req_proc_id} < 32'(MAX_PROCS));
   assign p_in       = IW'(req_proc_id);

   // key compare stage of the search
   assign cmp_hit  = cmp_vld_ff && active_ff[cmp_idx_ff] && (key_rd == key_ff);
   assign cmp_last = cmp_vld_ff && (cmp_idx_ff == LAST);

   // process to unlink and its place in the queue
   assign px      = (op_ff == OP_REMOVE) ? head_rd : p_ff;
   assign at_head = (h_ff == px_ff);
   assign at_tail = (t_ff == px_ff);
   assign np_ra   = (state_ff == S_HTD) ? px : px_ff;

   // memory write control
   always_comb begin
      key_we  = 1'b0;
      key_wa  = free_idx_ff;
      head_we = 1'b0;
      head_wa = d_ff;
      head_wd = p_ff;
      tail_we = 1'b0;
      tail_wa = d_ff;
      tail_wd = p_ff;
      next_we = 1'b0;
      next_wa = tail_rd;
      next_wd = p_ff;
      prev_we = 1'b0;
      prev_wa = p_ff;
      prev_wd = tail_rd;
      pdi_we  = 1'b0;
      pdi_wa  = p_ff;
      pdi_wd  = d_ff;
      unique case (state_ff)
         S_FIN: begin
            // new descriptor holding a single process
            if (out_free && op_ff == OP_INSERT && free_fnd_ff) begin
               key_we  = 1'b1;
               head_we = 1'b1;
               head_wa = free_idx_ff;
               tail_we = 1'b1;
               tail_wa = free_idx_ff;
               pdi_we  = 1'b1;
               pdi_wd  = free_idx_ff;
            end
         end
         S_HTD: begin
            // append at the tail of an existing queue
            if (out_free && op_ff == OP_INSERT) begin
               next_we = 1'b1;
               prev_we = 1'b1;
               tail_we = 1'b1;
               pdi_we  = 1'b1;
            end
         end
         S_NPD: begin
            if (out_free) begin
               if (at_head && !at_tail) begin
                  head_we = 1'b1;
                  head_wd = next_rd;
               end else if (at_tail && !at_head) begin
                  tail_we = 1'b1;
                  tail_wd = prev_rd;
               end else if (!at_head && !at_tail) begin
                  next_we = 1'b1;
                  next_wa = prev_rd;
                  next_wd = next_rd;
                  prev_we = 1'b1;
                  prev_wa = next_rd;
                  prev_wd = prev_rd;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // descriptor memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_ff;
      end
      key_rd <= key_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd <= head_mem[d_ff];
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[tail_wa] <= tail_wd;
      end
      tail_rd <= tail_mem[d_ff];
   end

   // process link memories
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_rd <= next_mem[np_ra];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      prev_rd <= prev_mem[np_ra];
   end

   always_ff @(posedge clock) begin
      if (pdi_we) begin
         pdi_mem[pdi_wa] <= pdi_wd;
      end
      pdi_rd <= pdi_mem[p_ff];
   end

   // sequencer, flags and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         blocked_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         issue_done_ff <= 1'b0;
         free_fnd_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  op_ff         <= op_type'(req_operation);
                  key_ff        <= KEY_WIDTH'(req_sem_key);
                  p_ff          <= p_in;
                  cnt_ff        <= '0;
                  issue_done_ff <= 1'b0;
                  cmp_vld_ff    <= 1'b0;
                  free_fnd_ff   <= 1'b0;
                  case (op_type'(req_operation))
                     OP_INSERT: begin
                        if (p_in_range && !blocked_ff[p_in]) begin
                           state_ff <= S_SCAN;
                        end else begin
                           state_ff <= S_REJ;
                        end
                     end
                     OP_OUT: begin
                        if (p_in_range && blocked_ff[p_in]) begin
                           state_ff <= S_PDI;
                        end else begin
                           state_ff <= S_REJ;
                        end
                     end
                     default: begin
                        state_ff <= S_SCAN;
                     end
                  endcase
               end
            end
            S_REJ: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= ST_NOT_FOUND;
                  rsp_result_proc_ff <= '0;
                  state_ff           <= S_IDLE;
               end
            end
            S_SCAN: begin
               // issue one key read per cycle
               cmp_idx_ff <= cnt_ff;
               cmp_vld_ff <= !issue_done_ff;
               if (cnt_ff == LAST) begin
                  issue_done_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               // remember the lowest free descriptor
               if (cmp_vld_ff && !active_ff[cmp_idx_ff] && !free_fnd_ff) begin
                  free_fnd_ff <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               if (cmp_hit) begin
                  d_ff       <= cmp_idx_ff;
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_HTA;
               end else if (cmp_last) begin
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_FIN;
               end
            end
            S_FIN: begin
               // key not present
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_result_proc_ff <= '0;
                  state_ff           <= S_IDLE;
                  if (op_ff != OP_INSERT) begin
                     rsp_status_ff <= ST_NOT_FOUND;
                  end else if (free_fnd_ff) begin
                     rsp_status_ff           <= ST_OK;
                     active_ff[free_idx_ff]  <= 1'b1;
                     blocked_ff[p_ff]        <= 1'b1;
                  end else begin
                     rsp_status_ff <= ST_FULL;
                  end
               end
            end
            S_PDI: begin
               state_ff <= S_PDIW;
            end
            S_PDIW: begin
               d_ff <= pdi_rd;
               if (active_ff[pdi_rd]) begin
                  state_ff <= S_HTA;
               end else begin
                  state_ff <= S_REJ;
               end
            end
            S_HTA: begin
               state_ff <= S_HTD;
            end
            S_HTD: begin
               h_ff  <= head_rd;
               t_ff  <= tail_rd;
               px_ff <= px;
               if (op_ff == OP_INSERT || op_ff == OP_HEAD) begin
                  if (out_free) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ST_OK;
                     state_ff      <= S_IDLE;
                     if (op_ff == OP_INSERT) begin
                        rsp_result_proc_ff <= '0;
                        blocked_ff[p_ff]   <= 1'b1;
                     end else begin
                        rsp_result_proc_ff <= 5'(head_rd);
                     end
                  end
               end else begin
                  state_ff <= S_NPD;
               end
            end
            S_NPD: begin
               // unlink and report the process
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= ST_OK;
                  rsp_result_proc_ff <= 5'(px_ff);
                  blocked_ff[px_ff]  <= 1'b0;
                  if (at_head && at_tail) begin
                     active_ff[d_ff] <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // a response only appears after work on a transaction
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != S_IDLE))
      else $error("response without a transaction in progress");

   // failed transactions report process zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_result_proc_ff == 5'd0))
      else $error("nonzero process on failed transaction");

   // there are never more active descriptors than blocked processes
   a_active_count: assert property (@(posedge clock) disable iff (reset)
      $countones(active_ff) <= $countones(blocked_ff))
      else $error("more active descriptors than blocked processes");

   // a held response is not overwritten while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_status_ff)
         && $stable(rsp_result_proc_ff)))
      else $error("stalled response changed");

endmodule : semaphore_wait_queue_table_unit

`default_nettype wire

@@ tb/semaphore_wait_queue_table_checker.sv @@
// checker for the semaphore wait queue table: predicts each response from the
// accepted request stream and compares status and result process; needs swqt_pkg
module semaphore_wait_queue_table_checker
   import swqt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_sem_key,
   input  logic [4:0]  req_proc_id,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [4:0]  rsp_result_proc,
   output int          fail_count,
   output int          pending_count,
   output int          response_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC = 32;

   typedef struct packed {
      status_type status;
      logic [4:0] result_proc;
   } response_type;

   // shadow copy of the table
   logic [31:0] key_of_desc [NPROC];
   logic        desc_busy [NPROC];
   logic [4:0]  first_proc [NPROC];
   logic [4:0]  last_proc [NPROC];
   logic [4:0]  next_proc [NPROC];
   logic [4:0]  prev_proc [NPROC];
   logic [4:0]  desc_of_proc [NPROC];
   logic        waiting [NPROC];

   response_type expected_responses [$];

   function automatic int lookup_key(logic [31:0] key);
      for (int d = 0; d < NPROC; d++)
         if (desc_busy[d] && key_of_desc[d] == key) return d;
      return NPROC;
   endfunction

   function automatic void unlink(int d, logic [4:0] p);
      if (first_proc[d] == p && last_proc[d] == p) begin
         desc_busy[d] = 1'b0;
      end else if (first_proc[d] == p) begin
         first_proc[d] = next_proc[p];
      end else if (last_proc[d] == p) begin
         last_proc[d] = prev_proc[p];
      end else begin
         next_proc[prev_proc[p]] = next_proc[p];
         prev_proc[next_proc[p]] = prev_proc[p];
      end
      waiting[p] = 1'b0;
   endfunction

   function automatic response_type apply_request(op_type op, logic [31:0] key,
                                                  logic [4:0] p);
      response_type r;
      int d;
      r.status = ST_NOT_FOUND;
      r.result_proc = '0;
      case (op)
         OP_INSERT: begin
            if (!waiting[p]) begin
               d = lookup_key(key);
               if (d < NPROC) begin
                  next_proc[last_proc[d]] = p;
                  prev_proc[p] = last_proc[d];
                  last_proc[d] = p;
                  r.status = ST_OK;
               end else begin
                  d = 0;
                  while (d < NPROC && desc_busy[d]) d++;
                  if (d < NPROC) begin
                     desc_busy[d] = 1'b1;
                     key_of_desc[d] = key;
                     first_proc[d] = p;
                     last_proc[d] = p;
                     r.status = ST_OK;
                  end else begin
                     r.status = ST_FULL;
                  end
               end
               if (r.status == ST_OK) begin
                  desc_of_proc[p] = d[4:0];
                  waiting[p] = 1'b1;
               end
            end
         end
         OP_REMOVE, OP_HEAD: begin
            d = lookup_key(key);
            if (d < NPROC) begin
               r.result_proc = first_proc[d];
               if (op == OP_REMOVE) unlink(d, first_proc[d]);
               r.status = ST_OK;
            end
         end
         default: begin
            if (waiting[p] && desc_busy[desc_of_proc[p]]) begin
               unlink(desc_of_proc[p], p);
               r.result_proc = p;
               r.status = ST_OK;
            end
         end
      endcase
      return r;
   endfunction

   assign pending_count = expected_responses.size();

   // predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         for (int i = 0; i < NPROC; i++) begin
            desc_busy[i] = 1'b0;
            waiting[i] = 1'b0;
         end
         expected_responses.delete();
         fail_count = 0;
         response_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response status=%0d proc=%0d", $time,
                        rsp_status, rsp_result_proc);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_status);
               end
               if (rsp_result_proc !== want.result_proc) begin
                  fail_count++;
                  $display("%0t: result_proc expected %0d actual %0d", $time,
                           want.result_proc, rsp_result_proc);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_responses.push_back(apply_request(op_type'(req_operation),
                                                       req_sem_key, req_proc_id));
      end
   end
endmodule

@@ tb/testbench.sv @@
// top of the semaphore wait queue table bench: clock, reset, request stimulus,
// response stall and verdict; depends on swqt_pkg, the unit and its checker
module testbench;
   import swqt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_sem_key = '0;
   logic [4:0]  req_proc_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_result_proc;
   int          fail_count, pending_count, response_count;
   bit          quiet_phase = 1'b0;

   // a few keys shared by most requests so queues grow deep
   logic [31:0] key_pool [8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hDEAD_BEEF};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   semaphore_wait_queue_table_unit dut (.*);

   semaphore_wait_queue_table_checker scoreboard (.*);

   // sender side: one transaction, with random gaps before it
   task automatic send_request(op_type op, logic [31:0] key, logic [4:0] p);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_sem_key <= key;
      req_proc_id <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver side: stall in short random bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // stimulus
   initial begin
      int sel;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, extremes, duplicate insert, out of idle process
      send_request(OP_HEAD, 32'h0, 5'd0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 5'd31);
      send_request(OP_OUT, 32'h0, 5'd31);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd31);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd31);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd7);
      send_request(OP_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_OUT, 32'h1, 5'd0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);

      // fill the table with one process per key, then free and refill descriptors
      for (int i = 0; i < 32; i++)
         send_request(OP_INSERT, 32'h100 + i, 5'(i));
      // drain once before the out and insert probes
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      send_request(OP_OUT, 32'h0, 5'd5);
      send_request(OP_INSERT, 32'hFFFF_0000, 5'd5);
      send_request(OP_OUT, 32'h0, 5'd6);
      send_request(OP_INSERT, 32'h100 + 6, 5'd5);
      send_request(OP_INSERT, 32'h7777_7777, 5'd6);
      for (int i = 0; i < 32; i++) send_request(OP_OUT, 32'h0, 5'(i));

      // random: mostly pooled keys, some fully random ones
      for (int n = 0; n < 1500; n++) begin
         if (n == 1300) quiet_phase = 1'b1;
         sel = $urandom_range(0, 9);
         send_request(op_type'(sel < 4 ? 0 : $urandom_range(1, 3)),
                      (sel == 9) ? $urandom() : key_pool[$urandom_range(0, 7)],
                      5'($urandom_range(0, 31)));
      end
      req_valid <= 1'b0;
      @(negedge clock);

      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d responses: empty and full table, duplicate insert,",
               response_count);
      $display("out of idle process, deep fifo queues on shared keys");
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // timeout
   initial begin
      #3ms;
      $display("status: fail");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/swqt_pkg.sv
rtl/semaphore_wait_queue_table_unit.sv
tb/semaphore_wait_queue_table_checker.sv
tb/testbench.sv
